// File: hdl/hg_pds_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hg_pds_pkg
// Types, constants and per-step functions of the Henyey-Greenstein
// direction sampler pipeline.
// ----------------------------------------------------------------------------
package hg_pds_pkg;

  localparam int DIV1_STEPS   = 40;
  localparam int DIV2_STEPS   = 15;
  localparam int CORDIC_STEPS = 16;
  localparam int SIN_STEPS    = 16;
  localparam int ROOT_STEPS   = 31;
  localparam int DIV3_STEPS   = 32;

  // in, gu, div1, tmul, tsq, div2, cos, cmul, sqrt, dmul, div3, fin, out
  localparam int LAT = 2 + (DIV1_STEPS + 1) + 2 + (DIV2_STEPS + 1) + 2 +
                       (ROOT_STEPS + 1) + 1 + (DIV3_STEPS + 1) + 2;

  localparam logic [0:0] REG_G_ASYMMETRY = 1'b0;
  localparam logic [0:0] REG_ISO_THRESH  = 1'b1;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
  localparam logic [28:0]        INV_4PI     = 29'd341782638;

  // atan(2^-i) in Q0.32 turns
  localparam logic [29:0] ATAN_TURNS [CORDIC_STEPS] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
    30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
    30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
    30'd166886,    30'd83443,     30'd41722,     30'd20861
  };

  typedef struct packed {
    logic [15:0] v;
    logic [15:0] u;
  } smp_t;

  typedef struct packed {
    logic signed [32:0] gu;
    smp_t               s;
  } gu_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] dd;
    logic [39:0] q;
    logic        ovf;
    smp_t        s;
  } div1_t;

  typedef struct packed {
    logic [47:0] p0;
    logic [40:0] p1;
    logic [33:0] p2;
    smp_t        s;
  } tmul_t;

  typedef struct packed {
    logic [63:0] tsq;
    smp_t        s;
  } tsq_t;

  typedef struct packed {
    logic [15:0] rem;
    logic [14:0] nlo;
    logic [14:0] q;
    logic        ovf;
    logic        neg;
    smp_t        s;
  } div2_t;

  typedef struct packed {
    logic signed [16:0] c;
    logic [15:0]        v;
  } cos_t;

  typedef struct packed {
    logic signed [33:0] csq;
    logic signed [32:0] gc;
    logic signed [16:0] c;
    logic [15:0]        v;
  } cmul_t;

  typedef struct packed {
    logic [31:0]        s_res;
    logic [31:0]        s_rem;
    logic [61:0]        r_res;
    logic [61:0]        r_rem;
    logic [32:0]        a_q;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic [1:0]         quad;
    logic signed [16:0] c;
  } sq_t;

  typedef struct packed {
    logic [48:0]        pl;
    logic [47:0]        ph;
    logic [15:0]        sin_t;
    logic signed [31:0] cphi;
    logic signed [31:0] sphi;
    logic signed [16:0] c;
  } dmul_t;

  typedef struct packed {
    logic [63:0]        rem;
    logic [63:0]        d;
    logic [31:0]        q;
    logic               ovf;
    logic [15:0]        sin_t;
    logic signed [31:0] cphi;
    logic signed [31:0] sphi;
    logic signed [16:0] c;
  } div3_t;

  typedef struct packed {
    logic signed [48:0] px;
    logic signed [48:0] pz;
    logic signed [16:0] c;
    logic [31:0]        pdf;
  } fin_t;

  function automatic div1_t div1_step(div1_t s, logic b);
    logic [32:0] r2;
    div1_t       o;
    o  = s;
    r2 = {s.rem, b};
    if (r2 >= {1'b0, s.dd}) begin
      r2  = r2 - {1'b0, s.dd};
      o.q = {s.q[38:0], 1'b1};
    end else begin
      o.q = {s.q[38:0], 1'b0};
    end
    o.rem = r2[31:0];
    return o;
  endfunction

  function automatic div2_t div2_step(div2_t s, logic [15:0] gabs);
    logic [16:0] r2;
    div2_t       o;
    o     = s;
    r2    = {s.rem, s.nlo[14]};
    o.nlo = {s.nlo[13:0], 1'b0};
    if (r2 >= {1'b0, gabs}) begin
      r2  = r2 - {1'b0, gabs};
      o.q = {s.q[13:0], 1'b1};
    end else begin
      o.q = {s.q[13:0], 1'b0};
    end
    o.rem = r2[15:0];
    return o;
  endfunction

  function automatic div3_t div3_step(div3_t s, logic b);
    logic [64:0] r2;
    div3_t       o;
    o  = s;
    r2 = {s.rem, b};
    if (r2 >= {1'b0, s.d}) begin
      r2  = r2 - {1'b0, s.d};
      o.q = {s.q[30:0], 1'b1};
    end else begin
      o.q = {s.q[30:0], 1'b0};
    end
    o.rem = r2[63:0];
    return o;
  endfunction

  // one sqrt(A) digit; k < 16 adds a sin digit and a CORDIC rotation
  function automatic sq_t sq_step(sq_t s, int k);
    logic [31:0] sb;
    logic [31:0] st;
    logic [61:0] rb;
    logic [61:0] rt;
    sq_t         o;
    o = s;
    if (k < SIN_STEPS) begin
      sb = 32'd1 << (30 - 2 * k);
      st = s.s_res + sb;
      if (s.s_rem >= st) begin
        o.s_rem = s.s_rem - st;
        o.s_res = (s.s_res >> 1) + sb;
      end else begin
        o.s_res = s.s_res >> 1;
      end
    end
    if (k < CORDIC_STEPS) begin
      if (!s.cz[31]) begin
        o.cx = s.cx - (s.cy >>> k);
        o.cy = s.cy + (s.cx >>> k);
        o.cz = s.cz - $signed({2'b00, ATAN_TURNS[k % CORDIC_STEPS]});
      end else begin
        o.cx = s.cx + (s.cy >>> k);
        o.cy = s.cy - (s.cx >>> k);
        o.cz = s.cz + $signed({2'b00, ATAN_TURNS[k % CORDIC_STEPS]});
      end
    end
    rb = 62'd1 << (60 - 2 * k);
    rt = s.r_res + rb;
    if (s.r_rem >= rt) begin
      o.r_rem = s.r_rem - rt;
      o.r_res = (s.r_res >> 1) + rb;
    end else begin
      o.r_res = s.r_res >> 1;
    end
    return o;
  endfunction

  function automatic logic [15:0] sat16(logic signed [48:0] w);
    logic [15:0] r;
    if (w > 49'sd32767) begin
      r = 16'h7FFF;
    end else if (w < -49'sd32768) begin
      r = 16'h8000;
    end else begin
      r = w[15:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hdl/hg_phase_direction_sample.sv
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one item per cycle while the output is not stalled; the long
// dividers, both square roots and the CORDIC are unrolled one step per
// register stage. A stalled output register holds the whole pipeline.
// Reset clears the valid chain, g to 0 and the isotropic threshold to 1.
// ----------------------------------------------------------------------------
// hg_phase_direction_sample
// Henyey-Greenstein scattering direction sampler: cosTheta by inverted
// distribution, sinTheta by root, azimuth by CORDIC, and the density.
// ----------------------------------------------------------------------------
module hg_phase_direction_sample
  import hg_pds_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // sample_u, sample_v
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [79:0]      m_axis_tdata,   // dir_x, dir_y, dir_z, pdf_value
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic signed [15:0] g_asymmetry;
  logic [14:0]        isotropic_threshold;

  logic [15:0] gabs_c;
  logic [31:0] gsq_c;
  logic [15:0] gabs;
  logic [30:0] gsq;
  logic [30:0] nm;
  logic        iso;
  logic        m_zero;
  logic [44:0] mk_pl;
  logic [43:0] mk_ph;
  logic [59:0] mk;
  logic [39:0] n1_bits;
  logic [31:0] n3_bits;

  logic [LAT-1:0] vld;
  logic           en;

  smp_t  in_r;
  gu_t   gu_r;
  div1_t d1 [DIV1_STEPS+1];
  tmul_t tm_r;
  tsq_t  ts_r;
  div2_t d2 [DIV2_STEPS+1];
  cos_t  cs_r;
  cmul_t cm_r;
  sq_t   sq [ROOT_STEPS+1];
  dmul_t dm_r;
  div3_t d3 [DIV3_STEPS+1];
  fin_t  fin_r;

  logic [15:0] out_x;
  logic [15:0] out_y;
  logic [15:0] out_z;
  logic [31:0] out_pdf;

  always_ff @(posedge clk) begin
    if (rst) begin
      g_asymmetry         <= '0;
      isotropic_threshold <= 15'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_G_ASYMMETRY: g_asymmetry <= cfg_data;
        REG_ISO_THRESH:  isotropic_threshold <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // values that follow from the registers alone
  assign gabs_c = g_asymmetry[15] ? 16'(-g_asymmetry) : g_asymmetry;
  assign gsq_c  = gabs_c * gabs_c;

  always_ff @(posedge clk) begin
    gabs   <= gabs_c;
    gsq    <= gsq_c[30:0];
    nm     <= 31'h4000_0000 - gsq_c[30:0];
    m_zero <= (gsq_c[30:0] == 31'h4000_0000);
    iso    <= (g_asymmetry == 16'sd0) || (gabs_c < {1'b0, isotropic_threshold});
    mk_pl  <= nm[15:0] * INV_4PI;
    mk_ph  <= nm[30:16] * INV_4PI;
    mk     <= 60'(mk_pl) + {mk_ph, 16'b0};
  end

  assign n1_bits = {nm[9:0], 30'b0};
  assign n3_bits = {mk[18:0], 13'b0};

  assign en            = !vld[LAT-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[LAT-1];
  assign m_axis_tdata  = {out_pdf, out_z, out_y, out_x};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_axis_tvalid};
    end
  end

  // front: input, g*(u-1/2), divider setup
  always_ff @(posedge clk) begin
    if (en) begin
      in_r      <= s_axis_tdata;
      gu_r.gu   <= g_asymmetry * $signed({1'b0, in_r.u} - 17'h08000);
      gu_r.s    <= in_r;
      d1[0].dd  <= 32'(33'sh0_4000_0000 + gu_r.gu);
      d1[0].rem <= 32'(nm[30:10]);
      d1[0].ovf <= ({11'b0, nm[30:10]} >= 32'(33'sh0_4000_0000 + gu_r.gu));
      d1[0].q   <= '0;
      d1[0].s   <= gu_r.s;
    end
  end

  // term1 = (1-g^2)/(1+g(2u-1)), Q30
  for (genvar k = 0; k < DIV1_STEPS; k++) begin : g_div1
    always_ff @(posedge clk) begin
      if (en) begin
        d1[k+1] <= div1_step(d1[k], n1_bits[DIV1_STEPS-1-k]);
      end
    end
  end

  logic [40:0] t_c;
  assign t_c = d1[DIV1_STEPS].ovf ? 41'h100_0000_0000 : {1'b0, d1[DIV1_STEPS].q};

  logic [63:0] num_c;
  logic [63:0] nabs_c;
  logic [64:0] x_c;
  assign num_c  = 64'h1000_0000_0000_0000 + {3'b0, gsq, 30'b0} - ts_r.tsq;
  assign nabs_c = num_c[63] ? -num_c : num_c;
  assign x_c    = {1'b0, nabs_c} + {19'b0, gabs, 30'b0};

  always_ff @(posedge clk) begin
    if (en) begin
      tm_r.p0 <= t_c[23:0] * t_c[23:0];
      tm_r.p1 <= t_c[40:24] * t_c[23:0];
      tm_r.p2 <= t_c[40:24] * t_c[40:24];
      tm_r.s  <= d1[DIV1_STEPS].s;
      ts_r.tsq <= 64'(tm_r.p0) + {tm_r.p1[38:0], 25'b0} + {tm_r.p2[15:0], 48'b0};
      ts_r.s   <= tm_r.s;
      d2[0].rem <= x_c[61:46];
      d2[0].nlo <= x_c[45:31];
      d2[0].ovf <= (x_c[64:46] >= {3'b0, gabs});
      d2[0].neg <= num_c[63] ^ g_asymmetry[15];
      d2[0].q   <= '0;
      d2[0].s   <= ts_r.s;
    end
  end

  // cosTheta = (1+g^2-term1^2)/(2g), rounded
  for (genvar k = 0; k < DIV2_STEPS; k++) begin : g_div2
    always_ff @(posedge clk) begin
      if (en) begin
        d2[k+1] <= div2_step(d2[k], gabs);
      end
    end
  end

  logic [15:0]        qm_c;
  logic signed [16:0] c_an;
  logic signed [16:0] c_iso;
  assign qm_c  = d2[DIV2_STEPS].ovf ? 16'h8000 : {1'b0, d2[DIV2_STEPS].q};
  assign c_an  = d2[DIV2_STEPS].neg ? -$signed({1'b0, qm_c}) : $signed({1'b0, qm_c});
  assign c_iso = $signed(17'h08000 - {1'b0, d2[DIV2_STEPS].s.u});

  logic signed [34:0] a_c;
  logic [31:0]        vph_c;
  assign a_c   = 35'sh0_4000_0000 + $signed({4'b0, gsq}) -
                 $signed({cm_r.gc[32], cm_r.gc, 1'b0});
  assign vph_c = {cm_r.v, 16'b0} + 32'h2000_0000;

  always_ff @(posedge clk) begin
    if (en) begin
      cs_r.c    <= iso ? c_iso : c_an;
      cs_r.v    <= d2[DIV2_STEPS].s.v;
      cm_r.csq  <= cs_r.c * cs_r.c;
      cm_r.gc   <= g_asymmetry * cs_r.c;
      cm_r.c    <= cs_r.c;
      cm_r.v    <= cs_r.v;
      sq[0].s_res <= '0;
      sq[0].s_rem <= {1'b0, 31'h4000_0000 - cm_r.csq[30:0]};
      sq[0].r_res <= '0;
      sq[0].r_rem <= a_c[34] ? '0 : {1'b0, a_c[32:0], 28'b0};
      sq[0].a_q   <= a_c[34] ? '0 : a_c[32:0];
      sq[0].cx    <= CORDIC_GAIN;
      sq[0].cy    <= '0;
      sq[0].cz    <= $signed({2'b00, vph_c[29:0]}) - 32'sh2000_0000;
      sq[0].quad  <= vph_c[31:30];
      sq[0].c     <= cm_r.c;
    end
  end

  // sinTheta root, sqrt(A) root and azimuth CORDIC side by side
  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_sq
    always_ff @(posedge clk) begin
      if (en) begin
        sq[k+1] <= sq_step(sq[k], k);
      end
    end
  end

  logic signed [31:0] cphi_c;
  logic signed [31:0] sphi_c;
  always_comb begin
    case (sq[ROOT_STEPS].quad)
      QUAD_0: begin
        cphi_c = sq[ROOT_STEPS].cx;
        sphi_c = sq[ROOT_STEPS].cy;
      end
      QUAD_1: begin
        cphi_c = -sq[ROOT_STEPS].cy;
        sphi_c = sq[ROOT_STEPS].cx;
      end
      QUAD_2: begin
        cphi_c = -sq[ROOT_STEPS].cx;
        sphi_c = -sq[ROOT_STEPS].cy;
      end
      QUAD_3: begin
        cphi_c = sq[ROOT_STEPS].cy;
        sphi_c = -sq[ROOT_STEPS].cx;
      end
      default: begin
        cphi_c = sq[ROOT_STEPS].cx;
        sphi_c = sq[ROOT_STEPS].cy;
      end
    endcase
  end

  logic [63:0] d_c;
  assign d_c = 64'(dm_r.pl) + {dm_r.ph, 16'b0};

  always_ff @(posedge clk) begin
    if (en) begin
      dm_r.pl    <= sq[ROOT_STEPS].a_q * sq[ROOT_STEPS].r_res[15:0];
      dm_r.ph    <= sq[ROOT_STEPS].a_q * sq[ROOT_STEPS].r_res[30:16];
      dm_r.sin_t <= sq[ROOT_STEPS].s_res[15:0];
      dm_r.cphi  <= cphi_c;
      dm_r.sphi  <= sphi_c;
      dm_r.c     <= sq[ROOT_STEPS].c;
      d3[0].rem   <= {23'b0, mk[59:19]};
      d3[0].d     <= d_c;
      d3[0].ovf   <= ({23'b0, mk[59:19]} >= d_c);
      d3[0].q     <= '0;
      d3[0].sin_t <= dm_r.sin_t;
      d3[0].cphi  <= dm_r.cphi;
      d3[0].sphi  <= dm_r.sphi;
      d3[0].c     <= dm_r.c;
    end
  end

  // pdf = (1-g^2)/(4pi A sqrt(A)), Q16.16
  for (genvar k = 0; k < DIV3_STEPS; k++) begin : g_div3
    always_ff @(posedge clk) begin
      if (en) begin
        d3[k+1] <= div3_step(d3[k], n3_bits[DIV3_STEPS-1-k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_r.px  <= $signed({1'b0, d3[DIV3_STEPS].sin_t}) * d3[DIV3_STEPS].cphi;
      fin_r.pz  <= $signed({1'b0, d3[DIV3_STEPS].sin_t}) * d3[DIV3_STEPS].sphi;
      fin_r.c   <= d3[DIV3_STEPS].c;
      fin_r.pdf <= m_zero ? '0 :
                   (d3[DIV3_STEPS].ovf ? 32'hFFFF_FFFF : d3[DIV3_STEPS].q);
      out_x   <= sat16((fin_r.px + 49'sd536870912) >>> 30);
      out_z   <= sat16((fin_r.pz + 49'sd536870912) >>> 30);
      out_y   <= (fin_r.c > 17'sd32767) ? 16'h7FFF : fin_r.c[15:0];
      out_pdf <= fin_r.pdf;
    end
  end

endmodule
`default_nettype wire

// File: hdl/hg_pds_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hg_pds_chk
// Port-level checks of the direction sampler, bound to the top level.
// ----------------------------------------------------------------------------
module hg_pds_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [31:0] s_axis_tdata,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [79:0] m_axis_tdata,
  input wire logic        cfg_we,
  input wire logic [0:0]  cfg_index,
  input wire logic [15:0] cfg_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result item changed while stalled");

  // input side is only held back by a full, stalled output
  a_in_ready: assert property (@(posedge clk)
    !m_axis_tvalid || m_axis_tready |-> s_axis_tready)
    else $error("input stalled with output free");

  a_rst_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result item after reset");

endmodule

bind hg_phase_direction_sample hg_pds_chk u_chk (.*);
`default_nettype wire
